// ----- sv/hsl2rgb_pkg.sv -----
package hsl2rgb_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int IN_BITS       = 12;
   localparam int QW            = FRACTION_BITS + 1;
   localparam int CH_COUNT      = 3;
   localparam int PIPE_DEPTH    = 7;

   localparam logic [IN_BITS:0] IN_MAX = 13'd4096;
   localparam logic [QW-1:0]    Q_HALF = QW'(1) << (FRACTION_BITS - 1);

   // hue geometry in degrees
   localparam int ANGLE_W = 9;
   localparam logic [ANGLE_W:0]   DEG_FULL     = 10'd360;
   localparam logic [ANGLE_W-1:0] DEG_RISE_END = 9'd60;
   localparam logic [ANGLE_W-1:0] DEG_HIGH_END = 9'd180;
   localparam logic [ANGLE_W-1:0] DEG_FALL_END = 9'd240;
   localparam logic [ANGLE_W-1:0] RED_OFFSET   = 9'd120;
   localparam logic [ANGLE_W-1:0] BLUE_OFFSET  = 9'd240;

   // ramp step fraction 0..60, product and reciprocal divide by 60
   localparam int FRAC_W    = 6;
   localparam int XW        = QW + FRAC_W;
   localparam int DIV_SHIFT = 32;
   localparam int DIV_MUL_W = 27;
   localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'((64'd1 << DIV_SHIFT) / 64'd60);
   localparam int PW        = XW + DIV_MUL_W;
   localparam logic [XW-1:0] DIV_BASE = XW'(60);

   localparam int BW = QW + 8;
   localparam logic [7:0] BYTE_MAX = 8'd255;

   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_HIGH,
      SEG_FALL,
      SEG_LOW
   } seg_type;

   typedef struct packed {
      logic [8:0]  hue_degrees;
      logic [12:0] saturation;
      logic [12:0] lightness;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   function automatic logic [QW-1:0] clamp_unit(input logic [IN_BITS:0] x);
      logic [IN_BITS:0] c;
      c = (x > IN_MAX) ? IN_MAX : x;
      return QW'(c) << (FRACTION_BITS - IN_BITS);
   endfunction

   // angle + offset, modulo 360; angle already below 360
   function automatic logic [ANGLE_W-1:0] wrap_add(input logic [ANGLE_W-1:0] a,
                                                   input logic [ANGLE_W-1:0] off);
      logic [ANGLE_W:0] sum;
      sum = {1'b0, a} + {1'b0, off};
      if (sum >= DEG_FULL) begin
         sum = sum - DEG_FULL;
      end
      return sum[ANGLE_W-1:0];
   endfunction

   function automatic seg_type classify(input logic [ANGLE_W-1:0] a);
      seg_type s;
      if (a < DEG_RISE_END) begin
         s = SEG_RISE;
      end else if (a < DEG_HIGH_END) begin
         s = SEG_HIGH;
      end else if (a < DEG_FALL_END) begin
         s = SEG_FALL;
      end else begin
         s = SEG_LOW;
      end
      return s;
   endfunction

   function automatic logic [FRAC_W-1:0] ramp_frac(input logic [ANGLE_W-1:0] a);
      logic [ANGLE_W-1:0] f;
      if (a < DEG_RISE_END) begin
         f = a;
      end else if (a >= DEG_HIGH_END && a < DEG_FALL_END) begin
         f = DEG_FALL_END - a;
      end else begin
         f = '0;
      end
      return f[FRAC_W-1:0];
   endfunction

endpackage

// ----- sv/hsl_to_rgb_converter_core.sv -----
// hsl to rgb pixel pipeline, seven register stages
// throughput: one pixel per clock; busy is always low, no stalls
// depth is set by the l*s multiply and the reciprocal divide by 60 per channel
// reset (synchronous, active high) clears the valid chain; payload registers are not reset
module hsl_to_rgb_converter_core import hsl2rgb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;

   // stage 0: clamp, hue wrap, segment decode
   logic [QW-1:0]     sat0_ff, sat0_in, lit0_ff, lit0_in;
   logic              grey0_ff, grey0_in;
   seg_type           seg0_ff  [CH_COUNT];
   seg_type           seg0_in  [CH_COUNT];
   logic [FRAC_W-1:0] frac0_ff [CH_COUNT];
   logic [FRAC_W-1:0] frac0_in [CH_COUNT];

   // stage 1: p = l*s
   logic [QW-1:0]     p1_ff, p1_in, sat1_ff, lit1_ff;
   logic              grey1_ff;
   seg_type           seg1_ff  [CH_COUNT];
   logic [FRAC_W-1:0] frac1_ff [CH_COUNT];

   // stage 2: bounds
   logic [QW-1:0]     t1_2_ff, t1_2_in, t2_2_ff, t2_2_in, d2_ff, d2_in, lit2_ff;
   logic              grey2_ff;
   seg_type           seg2_ff  [CH_COUNT];
   logic [FRAC_W-1:0] frac2_ff [CH_COUNT];

   // stage 3: d * fraction
   logic [XW-1:0]     x3_ff [CH_COUNT];
   logic [XW-1:0]     x3_in [CH_COUNT];
   logic [QW-1:0]     t1_3_ff, t2_3_ff, lit3_ff;
   logic              grey3_ff;
   seg_type           seg3_ff [CH_COUNT];

   // stage 4: quotient estimate
   logic [QW-1:0]     q4_ff [CH_COUNT];
   logic [QW-1:0]     q4_in [CH_COUNT];
   logic [XW-1:0]     x4_ff [CH_COUNT];
   logic [QW-1:0]     t1_4_ff, t2_4_ff, lit4_ff;
   logic              grey4_ff;
   seg_type           seg4_ff [CH_COUNT];

   // stage 5: corrected quotient, channel level
   logic [QW-1:0]     v5_ff [CH_COUNT];
   logic [QW-1:0]     v5_in [CH_COUNT];
   logic              rnd5_ff;

   // stage 6: scale to byte
   rsp_type           rsp_ff, rsp_in;

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], start & ~busy};

   always_comb begin
      logic [ANGLE_W-1:0] hue;
      logic [ANGLE_W-1:0] ang [CH_COUNT];
      hue = (req_payload.hue_degrees >= DEG_FULL[ANGLE_W-1:0])
            ? req_payload.hue_degrees - DEG_FULL[ANGLE_W-1:0]
            : req_payload.hue_degrees;
      ang[0] = wrap_add(hue, RED_OFFSET);
      ang[1] = hue;
      ang[2] = wrap_add(hue, BLUE_OFFSET);
      sat0_in  = clamp_unit(req_payload.saturation);
      lit0_in  = clamp_unit(req_payload.lightness);
      grey0_in = (req_payload.saturation == '0);
      for (int c = 0; c < CH_COUNT; c++) begin
         seg0_in[c]  = classify(ang[c]);
         frac0_in[c] = ramp_frac(ang[c]);
      end
   end

   always_comb begin
      logic [2*QW-1:0] prod;
      prod  = (2*QW)'(lit0_ff) * (2*QW)'(sat0_ff);
      p1_in = prod[FRACTION_BITS +: QW];
   end

   always_comb begin
      logic [QW:0] t2w;
      logic [QW:0] twol;
      if (lit1_ff < Q_HALF) begin
         t2w = {1'b0, lit1_ff} + {1'b0, p1_ff};
      end else begin
         t2w = {1'b0, lit1_ff} + {1'b0, sat1_ff} - {1'b0, p1_ff};
      end
      twol    = {lit1_ff, 1'b0};
      t2_2_in = t2w[QW-1:0];
      t1_2_in = (twol >= t2w) ? QW'(twol - t2w) : '0;
      d2_in   = t2_2_in - t1_2_in;
   end

   always_comb begin
      for (int c = 0; c < CH_COUNT; c++) begin
         x3_in[c] = XW'(d2_ff) * XW'(frac2_ff[c]);
      end
   end

   // floor(x/60) estimate: low by at most one
   always_comb begin
      logic [PW-1:0] prod;
      for (int c = 0; c < CH_COUNT; c++) begin
         prod     = PW'(x3_ff[c]) * PW'(DIV_MUL);
         q4_in[c] = prod[DIV_SHIFT +: QW];
      end
   end

   always_comb begin
      logic [XW-1:0] rem;
      logic [QW-1:0] q;
      for (int c = 0; c < CH_COUNT; c++) begin
         rem = x4_ff[c] - XW'(q4_ff[c]) * DIV_BASE;
         q   = (rem >= DIV_BASE) ? q4_ff[c] + QW'(1) : q4_ff[c];
         if (grey4_ff) begin
            v5_in[c] = lit4_ff;
         end else begin
            case (seg4_ff[c])
               SEG_RISE: v5_in[c] = t1_4_ff + q;
               SEG_HIGH: v5_in[c] = t2_4_ff;
               SEG_FALL: v5_in[c] = t1_4_ff + q;
               SEG_LOW:  v5_in[c] = t1_4_ff;
               default:  v5_in[c] = t1_4_ff;
            endcase
         end
      end
   end

   always_comb begin
      logic [BW-1:0] w;
      logic [8:0]    b;
      logic [7:0]    ch [CH_COUNT];
      for (int c = 0; c < CH_COUNT; c++) begin
         // v*255 as v*256 - v, grey path truncates
         w = (BW'(v5_ff[c]) << 8) - BW'(v5_ff[c]) + (rnd5_ff ? BW'(Q_HALF) : '0);
         b = w[FRACTION_BITS +: 9];
         ch[c] = (b > 9'(BYTE_MAX)) ? BYTE_MAX : b[7:0];
      end
      rsp_in.red   = ch[0];
      rsp_in.green = ch[1];
      rsp_in.blue  = ch[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sat0_ff  <= sat0_in;
      lit0_ff  <= lit0_in;
      grey0_ff <= grey0_in;
      seg0_ff  <= seg0_in;
      frac0_ff <= frac0_in;

      p1_ff    <= p1_in;
      sat1_ff  <= sat0_ff;
      lit1_ff  <= lit0_ff;
      grey1_ff <= grey0_ff;
      seg1_ff  <= seg0_ff;
      frac1_ff <= frac0_ff;

      t1_2_ff  <= t1_2_in;
      t2_2_ff  <= t2_2_in;
      d2_ff    <= d2_in;
      lit2_ff  <= lit1_ff;
      grey2_ff <= grey1_ff;
      seg2_ff  <= seg1_ff;
      frac2_ff <= frac1_ff;

      x3_ff    <= x3_in;
      t1_3_ff  <= t1_2_ff;
      t2_3_ff  <= t2_2_ff;
      lit3_ff  <= lit2_ff;
      grey3_ff <= grey2_ff;
      seg3_ff  <= seg2_ff;

      q4_ff    <= q4_in;
      x4_ff    <= x3_ff;
      t1_4_ff  <= t1_3_ff;
      t2_4_ff  <= t2_3_ff;
      lit4_ff  <= lit3_ff;
      grey4_ff <= grey3_ff;
      seg4_ff  <= seg3_ff;

      v5_ff    <= v5_in;
      rnd5_ff  <= ~grey4_ff;

      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = valid_ff[PIPE_DEPTH-1];
   assign rsp_payload = rsp_ff;

endmodule

// ----- sv/hsl2rgb_checker.sv -----
module hsl2rgb_checker import hsl2rgb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_valid,
   input rsp_type rsp_payload
);

   // the pipeline never pushes back
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   // every result belongs to a transaction taken earlier at the pipeline input
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without transaction");

   // zero saturation gives equal channels
   a_grey_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_payload.saturation == '0, PIPE_DEPTH)
      |-> rsp_payload.red == rsp_payload.green && rsp_payload.green == rsp_payload.blue)
      else $error("grey pixel with unequal channels");

   // zero lightness is black
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_payload.lightness == '0, PIPE_DEPTH)
      |-> rsp_payload.red == '0 && rsp_payload.green == '0 && rsp_payload.blue == '0)
      else $error("zero lightness not black");

   // full lightness is white
   a_white: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_payload.lightness >= IN_MAX, PIPE_DEPTH)
      |-> rsp_payload.red == BYTE_MAX && rsp_payload.green == BYTE_MAX
          && rsp_payload.blue == BYTE_MAX)
      else $error("full lightness not white");

endmodule

bind hsl_to_rgb_converter_core hsl2rgb_checker u_hsl2rgb_checker (.*);
